/* sv/olu_pkg.sv */
// ----------------------------------------------------------------------------
// olu_pkg
// Shared widths, command, operation and status codes, and the word types
// passed between the front end and the list engine of the ordered value list.
// ----------------------------------------------------------------------------
package olu_pkg;

  // Field widths
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Sizing
  localparam int LIST_DEPTH_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int QUEUE_DEPTH    = 2;

  // Command codes on the input stream
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Classified operations handed to the list engine
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_NOP    = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // One queued operation
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } olu_op_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] entry_value;
    logic [POS_W-1:0]         position;
    logic                     last;
    logic [COUNT_W-1:0]       entry_count;
  } olu_result_t;

endpackage

/* sv/olu_front.sv */
// ----------------------------------------------------------------------------
// olu_front
// Accepts command words, classifies the command code into an operation and
// holds the operations in a short queue for the list engine.
// ----------------------------------------------------------------------------
module olu_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [olu_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [olu_pkg::DATA_W-1:0]  in_value,
  output logic                               q_valid,
  input  logic                               q_ready,
  output olu_pkg::olu_op_t                   q_head
);

  localparam int PTR_W = (olu_pkg::QUEUE_DEPTH > 1) ? $clog2(olu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(olu_pkg::QUEUE_DEPTH + 1);

  olu_pkg::olu_op_t            q_mem_r [olu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [olu_pkg::OP_W-1:0]    op_code;
  logic                        push, pop;

  // Command classification
  always_comb begin
    unique case (in_cmd)
      olu_pkg::CMD_INSERT: op_code = olu_pkg::OP_INSERT;
      olu_pkg::CMD_APPEND: op_code = olu_pkg::OP_APPEND;
      olu_pkg::CMD_DELETE: op_code = olu_pkg::OP_DELETE;
      olu_pkg::CMD_CLEAR:  op_code = olu_pkg::OP_CLEAR;
      olu_pkg::CMD_READ:   op_code = olu_pkg::OP_READ;
      default:             op_code = olu_pkg::OP_NOP;
    endcase
  end

  // Queue control
  assign in_ready = (cnt_r != CNT_W'(olu_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(olu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(olu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op_code, value: in_value};
    end
  end

endmodule

/* sv/olu_back.sv */
// ----------------------------------------------------------------------------
// olu_back
// List engine: a row of entry cells with parallel compare and shift, a small
// sequencer for execute and read-out, and the result output register.
// ----------------------------------------------------------------------------
module olu_back #(
  parameter int LIST_DEPTH = olu_pkg::LIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  olu_pkg::olu_op_t      q_head,
  output logic                  out_valid,
  input  logic                  out_ready,
  output olu_pkg::olu_result_t  out_res
);

  localparam int OCC_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (OCC_W > olu_pkg::COUNT_W) ? OCC_W : olu_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [OCC_W-1:0]                  occ_r, occ_nxt;
  logic [olu_pkg::POS_W-1:0]         idx_r, idx_nxt;
  logic [olu_pkg::OP_W-1:0]          op_r;
  logic signed [olu_pkg::DATA_W-1:0] val_r;
  logic [LIST_DEPTH-1:0]             lt_r, eq_r;
  logic signed [olu_pkg::DATA_W-1:0] ent_r   [LIST_DEPTH];
  logic signed [olu_pkg::DATA_W-1:0] ent_nxt [LIST_DEPTH];
  logic                              out_valid_r, out_valid_nxt;
  olu_pkg::olu_result_t              res_r, res_nxt;

  logic [LIST_DEPTH-1:0]             lt_c, eq_c, ahead, hit;
  logic signed [olu_pkg::DATA_W-1:0] ins_cell [LIST_DEPTH];
  logic signed [olu_pkg::DATA_W-1:0] del_cell [LIST_DEPTH];
  logic signed [olu_pkg::DATA_W-1:0] app_cell [LIST_DEPTH];
  logic signed [olu_pkg::DATA_W-1:0] rd_win   [olu_pkg::MAX_RESULTS];
  logic [CMP_W-1:0]                  rd_n;
  logic                              rd_last, out_free, full;

  // Per-cell compare and shift network
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic used;
    assign used    = (OCC_W'(i) < occ_r);
    assign lt_c[i] = used && (ent_r[i] < q_head.value);
    assign eq_c[i] = used && (ent_r[i] == q_head.value);
    // all held entries up to here are smaller than the operand
    assign ahead[i] = &lt_r[i:0];
    // a match lies at or before this cell
    assign hit[i]   = |eq_r[i:0];
    assign app_cell[i] = (OCC_W'(i) == occ_r) ? val_r : ent_r[i];
    if (i == 0) begin : g_head
      assign ins_cell[i] = ahead[i] ? ent_r[i] : val_r;
    end else begin : g_body
      assign ins_cell[i] = ahead[i] ? ent_r[i] : (ahead[i-1] ? val_r : ent_r[i-1]);
    end
    if (i < LIST_DEPTH - 1) begin : g_pull
      assign del_cell[i] = hit[i] ? ent_r[i+1] : ent_r[i];
    end else begin : g_tail
      assign del_cell[i] = ent_r[i];
    end
  end

  // Read-out window over the first entries
  for (genvar k = 0; k < olu_pkg::MAX_RESULTS; k++) begin : g_win
    if (k < LIST_DEPTH) begin : g_on
      assign rd_win[k] = ent_r[k];
    end else begin : g_off
      assign rd_win[k] = '0;
    end
  end

  assign rd_n = (CMP_W'(occ_r) >= CMP_W'(olu_pkg::MAX_RESULTS)) ?
                CMP_W'(olu_pkg::MAX_RESULTS) : CMP_W'(occ_r);
  assign rd_last  = ((CMP_W'(idx_r) + CMP_W'(1)) == rd_n);
  assign out_free = !out_valid_r || out_ready;
  assign full     = (occ_r == OCC_W'(LIST_DEPTH));
  assign q_ready  = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    logic emit;
    emit          = 1'b0;
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          res_nxt   = '{status: olu_pkg::ST_OK, entry_value: '0, position: '0,
                        last: 1'b1, entry_count: '0};
          case (op_r)
            olu_pkg::OP_INSERT: begin
              if (full) begin
                res_nxt.status = olu_pkg::ST_FULL;
              end else begin
                ent_nxt = ins_cell;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            olu_pkg::OP_APPEND: begin
              if (full) begin
                res_nxt.status = olu_pkg::ST_FULL;
              end else begin
                ent_nxt = app_cell;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            olu_pkg::OP_DELETE: begin
              if (occ_r == '0) begin
                res_nxt.status = olu_pkg::ST_EMPTY;
              end else if (!hit[LIST_DEPTH-1]) begin
                res_nxt.status = olu_pkg::ST_MISSING;
              end else begin
                ent_nxt = del_cell;
                occ_nxt = occ_r - OCC_W'(1);
              end
            end
            olu_pkg::OP_CLEAR: begin
              occ_nxt = '0;
            end
            olu_pkg::OP_READ: begin
              if (occ_r == '0) begin
                res_nxt.status = olu_pkg::ST_EMPTY;
              end else begin
                emit      = 1'b0;
                idx_nxt   = '0;
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
          res_nxt.entry_count = olu_pkg::COUNT_W'(occ_nxt);
        end
      end
      S_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          res_nxt = '{status: olu_pkg::ST_OK, entry_value: rd_win[idx_r], position: idx_r,
                      last: rd_last, entry_count: olu_pkg::COUNT_W'(occ_r)};
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + olu_pkg::POS_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: entry cells, operand, compare flags, result word
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    if (q_valid && q_ready) begin
      op_r <= q_head.op;
      val_r <= q_head.value;
      lt_r <= lt_c;
      eq_r <= eq_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

/* sv/ordered_value_list_unit.sv */
// ----------------------------------------------------------------------------
// ordered_value_list_unit
// Bounded ordered list of signed Q16.16 values driven by a command stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a command (insert, append, delete, clear, read out) and
//   a value. Each command gives one result word with last set, except read
//   out of a non-empty list, which gives one word per entry (up to 16) in
//   list order with last on the final one. Every result carries the status
//   and the entry count after the command.
//   A two-entry queue sits between the input and the list engine, so input
//   words are taken while the engine works or the output is stalled.
//   Sequence: a command is popped while the engine is idle and executed
//   once the output register is free, and the next command is taken only
//   when the engine is idle again; each result is visible the cycle after execution.
//   Insert and delete use parallel compare in every cell, then one shift.
//   When out_tready is low the output word holds and the engine waits;
//   the input keeps filling the queue until it is full.
//   Reset (rst_n low, synchronous) empties the list and drops queued and
//   pending words.
// ----------------------------------------------------------------------------
module ordered_value_list_unit #(
  parameter int LIST_DEPTH = olu_pkg::LIST_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [olu_pkg::IN_TDATA_W-1:0]     in_tdata,   // command[2:0], value[34:3]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [olu_pkg::OUT_TDATA_W-1:0]    out_tdata,  // status[1:0], entry_value[33:2],
                                                         // position[37:34], entry_count[42:38]
  output logic                               out_tlast
);

  logic                 q_valid, q_ready;
  olu_pkg::olu_op_t     q_head;
  olu_pkg::olu_result_t res;

  // Front end: accept and classify
  olu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tdata[olu_pkg::CMD_W-1:0]),
    .in_value ($signed(in_tdata[olu_pkg::CMD_W +: olu_pkg::DATA_W])),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_head   (q_head)
  );

  // List engine
  olu_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_head    (q_head),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Output word packing
  assign out_tdata = {5'b0, res.entry_count, res.position, res.entry_value, res.status};
  assign out_tlast = res.last;

`ifndef ASSERT_OFF
  // Any status other than ok ends the command and carries no entry
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status != olu_pkg::ST_OK) |->
      res.last && (res.position == '0) && (res.entry_value == '0))
    else $error("non-ok result carries entry data");

  // Read-out words follow back to back with rising positions
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !res.last |=>
      out_tvalid && (res.position == $past(res.position) + olu_pkg::POS_W'(1)))
    else $error("read-out sequence broken");

  // A read-out word that is not the last one implies held entries
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.last |-> (res.status == olu_pkg::ST_OK) && (res.entry_count != '0))
    else $error("read-out from an empty list");
`endif

endmodule
